// File: hw/rtl/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg: shared types and helpers for the quaternion arithmetic unit
// Action codes, multiplier term schedule, saturation and magnitude helpers.
// ----------------------------------------------------------------------------
package qau_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int MAX_EXPONENT_DEF  = 255;

	localparam int COMP_W  = 32;
	localparam int EXP_W   = 9;
	localparam int ACT_W   = 4;
	localparam int ZB_W    = 17;
	localparam int IN_DATA_W  = 272;  // 8 x 32 + 9, padded to bytes
	localparam int OUT_DATA_W = 128;
	localparam int OUT_USER_W = 4;

	localparam logic [ZB_W-1:0] ZB_RESET = 17'd1;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD  = 4'd0,
		ACT_SUB  = 4'd1,
		ACT_MUL  = 4'd2,
		ACT_DIV  = 4'd3,
		ACT_INV  = 4'd4,
		ACT_NORM = 4'd5,
		ACT_CONJ = 4'd6,
		ACT_POW  = 4'd7,
		ACT_NEG  = 4'd8
	} action_t;

	// one partial product of the Hamilton product
	typedef struct packed {
		logic [1:0] xi;   // left operand component
		logic [1:0] yi;   // right operand component
		logic [1:0] tgt;  // result component
		logic       neg;  // subtract instead of add
	} mul_sel_t;

	// term k: result component k[3:2], term k[1:0]
	function automatic mul_sel_t mul_sel(input logic [3:0] k);
		mul_sel_t s;
		s.tgt = k[3:2];
		s.neg = 1'b0;
		s.xi  = 2'd0;
		s.yi  = 2'd0;
		case (k)
			4'd0:  begin s.xi = 2'd0; s.yi = 2'd0; end
			4'd1:  begin s.xi = 2'd1; s.yi = 2'd1; s.neg = 1'b1; end
			4'd2:  begin s.xi = 2'd2; s.yi = 2'd2; s.neg = 1'b1; end
			4'd3:  begin s.xi = 2'd3; s.yi = 2'd3; s.neg = 1'b1; end
			4'd4:  begin s.xi = 2'd0; s.yi = 2'd1; end
			4'd5:  begin s.xi = 2'd1; s.yi = 2'd0; end
			4'd6:  begin s.xi = 2'd2; s.yi = 2'd3; end
			4'd7:  begin s.xi = 2'd3; s.yi = 2'd2; s.neg = 1'b1; end
			4'd8:  begin s.xi = 2'd0; s.yi = 2'd2; end
			4'd9:  begin s.xi = 2'd2; s.yi = 2'd0; end
			4'd10: begin s.xi = 2'd1; s.yi = 2'd3; s.neg = 1'b1; end
			4'd11: begin s.xi = 2'd3; s.yi = 2'd1; end
			4'd12: begin s.xi = 2'd0; s.yi = 2'd3; end
			4'd13: begin s.xi = 2'd3; s.yi = 2'd0; end
			4'd14: begin s.xi = 2'd1; s.yi = 2'd2; end
			4'd15: begin s.xi = 2'd2; s.yi = 2'd1; s.neg = 1'b1; end
			default: begin s.xi = 2'd0; s.yi = 2'd0; end
		endcase
		return s;
	endfunction

	function automatic logic [31:0] sat33(input logic [32:0] v);
		logic [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// |v| as unsigned; -2^31 maps to 2^31
	function automatic logic [31:0] mag32(input logic [31:0] v);
		logic [31:0] r;
		r = v[31] ? (32'd0 - v) : v;
		return r;
	endfunction

endpackage

// File: hw/rtl/quaternion_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_core: fixed-point quaternion ALU
// Add, subtract, Hamilton product, divide, inverse, normalize, conjugate,
// integer power and negate on signed Q16.16 quaternions, with status flags.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one operation per beat: action in tuser, operands a, b and
//  the exponent in tdata. m_axis returns one beat per operation: four
//  saturated components in tdata, four status flags in tuser. cfg_* writes
//  the zero/equality tolerance zero_bound; it is always ready. The user must
//  write it only while the unit is idle; the unit does not enforce this. Reset
//  sets zero_bound to 1 and empties the unit.
//  One beat is worked on at a time; s_axis_tready is high only when idle.
//  Every beat first runs the equality test (4 squares on the shared 32x32
//  multiplier plus a 32-step square root); add, sub, conjugate and negate
//  then go to the output stage. The Hamilton product adds 16 products
//  through the one multiplier. Inverse, divide, normalize and negative
//  power add 4 restoring divisions of 33+FRACTION_BITS steps each;
//  normalize first adds another root. Power adds one Hamilton product
//  per repeat, up to MAX_EXPONENT repeats.
//  The result sits in an output register; a stalled receiver holds it while
//  the next beat is already accepted and worked on. The unit waits in its
//  final step only if the register is still full.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_core
	import qau_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int MAX_EXPONENT  = MAX_EXPONENT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// a_real, a_i, a_j, a_k, b_real, b_i, b_j, b_k (32 b each), exponent (9 b)
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// action (4 b)
	input  logic [ACT_W-1:0]      s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_real, out_i, out_j, out_k (32 b each)
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// zero_division, equal_flag, real_only, pure_imaginary
	output logic [OUT_USER_W-1:0] m_axis_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [ZB_W-1:0]       cfg_data
);

	localparam int ACC_W  = 66 - FRACTION_BITS;          // signed sum of four products
	localparam int N2_W   = 65 - FRACTION_BITS;          // squared norm
	localparam int NUM_W  = 32 + FRACTION_BITS;          // scaled dividend
	localparam int DCNT_W = $clog2(NUM_W + 1);
	localparam int CNT_W  = (MAX_EXPONENT > 1) ? $clog2(MAX_EXPONENT + 1) : 1;
	localparam logic [4:0] MAC_SQ_N = 5'd4;
	localparam logic [4:0] MAC_QM_N = 5'd16;
	localparam logic [31:0] ONE_FX = 32'd1 << FRACTION_BITS;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_NEXT = 7'b0000010,
		S_MAC  = 7'b0000100,
		S_SQRT = 7'b0001000,
		S_DIV  = 7'b0010000,
		S_OUT  = 7'b0100000,
		S_SPARE = 7'b1000000
	} state_t;

	typedef enum logic [8:0] {
		PH_START   = 9'b000000001,
		PH_EQ_N2   = 9'b000000010,
		PH_EQ_SQRT = 9'b000000100,
		PH_N2      = 9'b000001000,
		PH_SQRT    = 9'b000010000,
		PH_DIV     = 9'b000100000,
		PH_MUL     = 9'b001000000,
		PH_POW     = 9'b010000000,
		PH_POWM    = 9'b100000000
	} phase_t;

	state_t state_q;
	phase_t phase_q;
	logic [ZB_W-1:0] zb_q;

	// operands and working vectors
	logic [31:0] a_q [4];
	logic [31:0] b_q [4];
	logic [31:0] x_q [4];
	logic [31:0] y_q [4];
	logic [31:0] r_q [4];
	action_t     act_q;
	logic [EXP_W-1:0] exp_q;
	logic [CNT_W-1:0] pcnt_q;
	logic zdiv_q, eq_q;

	// multiply-accumulate
	logic [4:0] mcnt_q;
	logic sq_q;
	logic signed [63:0] prod_s1;
	logic vld_s1, neg_s1;
	logic [1:0] tgt_s1;
	logic signed [ACC_W-1:0] acc_q [4];

	// square root
	logic [63:0] sx_q, sres_q, sbit_q;

	// divider
	logic [1:0] di_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [N2_W-1:0] rem_q, dv_q;
	logic [NUM_W-1:0] quo_q;
	logic dneg_q;

	logic [31:0] out_q [4];
	logic [OUT_USER_W-1:0] flags_q;
	logic m_tvalid_q;

	function automatic logic [31:0] sat_acc(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-32:0] hi;
		logic [31:0] r;
		hi = v[ACC_W-1:31];
		if ((&hi) || !(|hi)) begin
			r = v[31:0];
		end else begin
			r = v[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return r;
	endfunction

	// ---------------- combinational helpers ----------------
	logic [31:0] d_c [4];
	logic [31:0] sum_c [4];
	logic [31:0] neg_c [4];
	always_comb begin
		for (int n = 0; n < 4; n++) begin
			d_c[n]   = sat33({a_q[n][31], a_q[n]} - {b_q[n][31], b_q[n]});
			sum_c[n] = sat33({a_q[n][31], a_q[n]} + {b_q[n][31], b_q[n]});
			neg_c[n] = sat33(33'd0 - {a_q[n][31], a_q[n]});
		end
	end

	mul_sel_t msel;
	logic [1:0] xidx;
	logic signed [31:0] op_a, op_b;
	logic [4:0] mlast;
	logic mac_done;
	always_comb begin
		msel = sq_q ? mul_sel_t'{xi: mcnt_q[1:0], yi: mcnt_q[1:0], tgt: 2'd0, neg: 1'b0}
		            : mul_sel(mcnt_q[3:0]);
		case (state_q)
			S_MAC:   xidx = msel.xi;
			S_DIV:   xidx = di_q + 2'd1;
			default: xidx = 2'd0;
		endcase
	end
	assign op_a     = x_q[xidx];
	assign op_b     = sq_q ? x_q[xidx] : y_q[msel.yi];
	assign mlast    = sq_q ? MAC_SQ_N : MAC_QM_N;
	assign mac_done = (mcnt_q == mlast);

	logic signed [63:0] prod_sh;
	logic signed [ACC_W-1:0] flr_c;
	assign prod_sh = prod_s1 >>> FRACTION_BITS;
	assign flr_c   = ACC_W'(prod_sh);

	// squared norm, root input clamped as in the norm definition
	logic [N2_W-1:0] n2_c;
	logic [63:0] sqrt_in_c;
	logic n2_zero, nm_zero;
	assign n2_c      = acc_q[0][N2_W-1:0];
	assign sqrt_in_c = n2_c[N2_W-1] ? '1 : {n2_c[N2_W-2:0], {FRACTION_BITS{1'b0}}};
	assign n2_zero   = (n2_c <= N2_W'(zb_q));
	assign nm_zero   = (sres_q <= 64'(zb_q));

	logic [63:0] strial_c;
	logic sqrt_ge, sqrt_done;
	assign strial_c  = sres_q + sbit_q;
	assign sqrt_ge   = (sx_q >= strial_c);
	assign sqrt_done = (sbit_q == 64'd1);

	// divider numerator for the component at xidx
	logic div_inv;
	logic [31:0] dmag_c;
	logic dneg_c;
	logic [1:0] dnext;
	assign div_inv = (act_q != ACT_NORM);
	assign dmag_c  = mag32(x_q[xidx]);
	assign dnext   = (state_q == S_DIV) ? di_q + 2'd1 : 2'd0;
	assign dneg_c  = (div_inv && (dnext != 2'd0)) ? (!x_q[xidx][31] && (x_q[xidx] != 32'd0))
	                                              : x_q[xidx][31];

	logic [N2_W:0] dtrial_c;
	logic dge;
	logic div_step_end, div_last;
	logic [31:0] qsat_c;
	assign dtrial_c     = {rem_q, quo_q[NUM_W-1]};
	assign dge          = (dtrial_c >= {1'b0, dv_q});
	assign div_step_end = (dcnt_q == DCNT_W'(NUM_W));
	assign div_last     = div_step_end && (di_q == 2'd3);
	always_comb begin
		if (dneg_q) begin
			qsat_c = (quo_q > (NUM_W'(1) << 31)) ? 32'h8000_0000 : (32'd0 - quo_q[31:0]);
		end else begin
			qsat_c = (quo_q > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo_q[31:0];
		end
	end

	logic [EXP_W-1:0] pabs_c;
	logic exp_neg, exp_zero;
	assign exp_neg  = exp_q[EXP_W-1];
	assign exp_zero = (exp_q == '0);
	assign pabs_c   = exp_neg ? (EXP_W'(0) - exp_q) : exp_q;

	logic out_load;
	assign out_load = (state_q == S_OUT) && (!m_tvalid_q || m_axis_tready);

	logic real_only_c, pure_im_c;
	assign real_only_c = (mag32(a_q[1]) <= 32'(zb_q)) && (mag32(a_q[2]) <= 32'(zb_q))
	                  && (mag32(a_q[3]) <= 32'(zb_q));
	assign pure_im_c   = (mag32(a_q[0]) <= 32'(zb_q)) && !real_only_c;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= PH_START;
			zb_q       <= ZB_RESET;
			m_tvalid_q <= 1'b0;
			vld_s1     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				zb_q <= cfg_data;
			end
			vld_s1 <= (state_q == S_MAC) && (mcnt_q < mlast);
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_NEXT;
						phase_q <= PH_START;
					end
				end
				S_MAC: if (mac_done) state_q <= S_NEXT;
				S_SQRT: if (sqrt_done) state_q <= S_NEXT;
				S_DIV: if (div_last) state_q <= S_NEXT;
				S_OUT: if (out_load) state_q <= S_IDLE;
				S_NEXT: begin
					case (phase_q)
						PH_START: begin
							state_q <= S_MAC;
							phase_q <= PH_EQ_N2;
						end
						PH_EQ_N2: begin
							state_q <= S_SQRT;
							phase_q <= PH_EQ_SQRT;
						end
						PH_EQ_SQRT: begin
							case (act_q)
								ACT_MUL: begin
									state_q <= S_MAC;
									phase_q <= PH_MUL;
								end
								ACT_DIV, ACT_INV, ACT_NORM: begin
									state_q <= S_MAC;
									phase_q <= PH_N2;
								end
								ACT_POW: begin
									if (exp_zero) begin
										state_q <= S_OUT;
									end else if (exp_neg) begin
										state_q <= S_MAC;
										phase_q <= PH_N2;
									end else begin
										phase_q <= PH_POW;
									end
								end
								default: state_q <= S_OUT;
							endcase
						end
						PH_N2: begin
							if (act_q == ACT_NORM) begin
								state_q <= S_SQRT;
								phase_q <= PH_SQRT;
							end else if (n2_zero) begin
								state_q <= S_OUT;
							end else begin
								state_q <= S_DIV;
								phase_q <= PH_DIV;
							end
						end
						PH_SQRT: begin
							if (nm_zero) begin
								state_q <= S_OUT;
							end else begin
								state_q <= S_DIV;
								phase_q <= PH_DIV;
							end
						end
						PH_DIV: begin
							if (act_q == ACT_DIV) begin
								state_q <= S_MAC;
								phase_q <= PH_MUL;
							end else if (act_q == ACT_POW) begin
								phase_q <= PH_POW;
							end else begin
								state_q <= S_OUT;
							end
						end
						PH_MUL: state_q <= S_OUT;
						PH_POW: begin
							if (pcnt_q == '0) begin
								state_q <= S_OUT;
							end else begin
								state_q <= S_MAC;
								phase_q <= PH_POWM;
							end
						end
						PH_POWM: phase_q <= PH_POW;
						default: state_q <= S_OUT;
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					for (int n = 0; n < 4; n++) begin
						a_q[n] <= s_axis_tdata[32*n +: 32];
						b_q[n] <= s_axis_tdata[128 + 32*n +: 32];
					end
					exp_q  <= s_axis_tdata[256 +: EXP_W];
					act_q  <= action_t'(s_axis_tuser);
					zdiv_q <= 1'b0;
				end
			end
			S_NEXT: begin
				case (phase_q)
					PH_START: begin
						x_q    <= d_c;
						sq_q   <= 1'b1;
						mcnt_q <= '0;
						for (int n = 0; n < 4; n++) acc_q[n] <= '0;
					end
					PH_EQ_N2: begin
						sx_q   <= sqrt_in_c;
						sres_q <= '0;
						sbit_q <= 64'd1 << 62;
					end
					PH_EQ_SQRT: begin
						eq_q <= nm_zero;
						if (32'(pabs_c) > 32'(MAX_EXPONENT)) begin
							pcnt_q <= CNT_W'(MAX_EXPONENT);
						end else begin
							pcnt_q <= CNT_W'(pabs_c);
						end
						mcnt_q <= '0;
						for (int n = 0; n < 4; n++) acc_q[n] <= '0;
						case (act_q)
							ACT_ADD: r_q <= sum_c;
							ACT_SUB: r_q <= d_c;
							ACT_MUL: begin
								x_q  <= a_q;
								y_q  <= b_q;
								sq_q <= 1'b0;
							end
							ACT_DIV: begin
								x_q  <= b_q;
								sq_q <= 1'b1;
							end
							ACT_INV, ACT_NORM: begin
								x_q  <= a_q;
								sq_q <= 1'b1;
							end
							ACT_CONJ: begin
								r_q[0] <= a_q[0];
								for (int n = 1; n < 4; n++) r_q[n] <= neg_c[n];
							end
							ACT_NEG: r_q <= neg_c;
							ACT_POW: begin
								r_q[0] <= ONE_FX;
								for (int n = 1; n < 4; n++) r_q[n] <= '0;
								y_q  <= a_q;
								x_q  <= a_q;
								sq_q <= 1'b1;
							end
							default: for (int n = 0; n < 4; n++) r_q[n] <= '0;
						endcase
					end
					PH_N2: begin
						if (act_q == ACT_NORM) begin
							sx_q   <= sqrt_in_c;
							sres_q <= '0;
							sbit_q <= 64'd1 << 62;
						end else if (n2_zero) begin
							zdiv_q <= 1'b1;
						end else begin
							dv_q   <= n2_c;
							di_q   <= '0;
							dcnt_q <= '0;
							rem_q  <= '0;
							quo_q  <= {dmag_c, {FRACTION_BITS{1'b0}}};
							dneg_q <= dneg_c;
						end
					end
					PH_SQRT: begin
						if (nm_zero) begin
							zdiv_q <= 1'b1;
						end else begin
							dv_q   <= N2_W'(sres_q[31:0]);
							di_q   <= '0;
							dcnt_q <= '0;
							rem_q  <= '0;
							quo_q  <= {dmag_c, {FRACTION_BITS{1'b0}}};
							dneg_q <= dneg_c;
						end
					end
					PH_DIV: begin
						if (act_q == ACT_DIV) begin
							x_q    <= a_q;
							y_q    <= r_q;
							sq_q   <= 1'b0;
							mcnt_q <= '0;
							for (int n = 0; n < 4; n++) acc_q[n] <= '0;
						end else if (act_q == ACT_POW) begin
							y_q    <= r_q;
							r_q[0] <= ONE_FX;
							for (int n = 1; n < 4; n++) r_q[n] <= '0;
						end
					end
					PH_MUL, PH_POWM: begin
						for (int n = 0; n < 4; n++) r_q[n] <= sat_acc(acc_q[n]);
					end
					PH_POW: begin
						if (pcnt_q != '0) begin
							x_q    <= r_q;
							pcnt_q <= pcnt_q - CNT_W'(1);
							sq_q   <= 1'b0;
							mcnt_q <= '0;
							for (int n = 0; n < 4; n++) acc_q[n] <= '0;
						end
					end
					default: ;
				endcase
			end
			S_MAC: begin
				if (mcnt_q < mlast) begin
					prod_s1 <= op_a * op_b;
					tgt_s1  <= msel.tgt;
					neg_s1  <= msel.neg;
				end
				if (vld_s1) begin
					acc_q[tgt_s1] <= neg_s1 ? (acc_q[tgt_s1] - flr_c) : (acc_q[tgt_s1] + flr_c);
				end
				mcnt_q <= mcnt_q + 5'd1;
			end
			S_SQRT: begin
				if (sqrt_ge) begin
					sx_q   <= sx_q - strial_c;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			S_DIV: begin
				if (!div_step_end) begin
					rem_q  <= dge ? N2_W'(dtrial_c - {1'b0, dv_q}) : N2_W'(dtrial_c);
					quo_q  <= {quo_q[NUM_W-2:0], dge};
					dcnt_q <= dcnt_q + DCNT_W'(1);
				end else begin
					r_q[di_q] <= qsat_c;
					di_q      <= di_q + 2'd1;
					dcnt_q    <= '0;
					rem_q     <= '0;
					quo_q     <= {dmag_c, {FRACTION_BITS{1'b0}}};
					dneg_q    <= dneg_c;
				end
			end
			S_OUT: begin
				if (out_load) begin
					for (int n = 0; n < 4; n++) out_q[n] <= zdiv_q ? 32'd0 : r_q[n];
					flags_q <= {pure_im_c, real_only_c, eq_q, zdiv_q};
				end
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {out_q[3], out_q[2], out_q[1], out_q[0]};
	assign m_axis_tuser  = flags_q;

	// ---------------- checks ----------------
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("sequencer state not one-hot");

	a_mac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC) |-> (mcnt_q <= mlast)) else $error("MAC counter overrun");

	a_zdiv_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
		else $error("zero-division result not cleared");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[2] && m_axis_tuser[3]))
		else $error("real-only and pure-imaginary both set");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("accepted a beat while busy");

endmodule
